// ===== hdl/wm17_pkg.sv =====
// Shared types, constants and the multiply-by-17 update for the word checksum.
package wm17_pkg;

    localparam int unsigned WORD_BITS    = 64;
    localparam int unsigned WORD_BYTES   = 8;
    localparam int unsigned PART_BITS    = 56;
    localparam int unsigned PCNT_BITS    = 3;
    localparam int unsigned BCNT_BITS    = 4;
    localparam int unsigned CSUM_BITS    = 32;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [PART_BITS-1:0] t_part;

    typedef struct packed {
        t_word sum;
        t_part part;
        logic  pend;
    } t_fin;

    function automatic t_word mul17_add(input t_word sum, input t_word addend);
        mul17_add = (sum << 4) + sum + addend;
    endfunction

endpackage

// ===== hdl/word_multiply17_checksum_unit.sv =====
// Top level of the streaming multiply-by-17 word checksum.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+------------------------------------------
//  input   | i_in_valid   | o_in_ready   | i_data_bytes, i_byte_count, i_last
//  output  | o_out_valid  | i_out_ready  | o_checksum
//
// One transaction per cycle sustained unless a last one waits on the fold stages;
// the sum*17 + word update is combinational; a last goes through stages A, B and C.
// Reset (synchronous, active low) clears the running sum, partial word and all valids.
// A stalled output backs up through the pipeline stages; empty stages still fill.
module word_multiply17_checksum_unit
    import wm17_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [63:0]          i_data_bytes,
    input  logic [BCNT_BITS-1:0] i_byte_count,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CSUM_BITS-1:0] o_checksum
);

    logic                 r_a_valid;
    t_word                r_a_data;
    logic [BCNT_BITS-1:0] r_a_cnt;
    logic                 r_a_last;

    logic                 a_go;
    logic                 fin_ready;
    t_fin                 fin;

    assign a_go       = r_a_valid && (!r_a_last || fin_ready);
    assign o_in_ready = !r_a_valid || a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_data <= i_data_bytes;
            r_a_cnt  <= i_byte_count;
            r_a_last <= i_last;
        end
    end

    wm17_pack_update u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (a_go),
        .i_data  (r_a_data),
        .i_cnt   (r_a_cnt),
        .i_last  (r_a_last),
        .o_fin   (fin)
    );

    wm17_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (a_go && r_a_last),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .o_out_valid (o_out_valid),
        .o_checksum  (o_checksum),
        .i_out_ready (i_out_ready)
    );

endmodule

// ===== hdl/wm17_pack_update.sv =====
// Byte packing and running-sum update; hands the closing state of a message onward.
module wm17_pack_update
    import wm17_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  t_word                i_data,
    input  logic [BCNT_BITS-1:0] i_cnt,
    input  logic                 i_last,
    output t_fin                 o_fin
);

    t_word                r_sum;
    t_part                r_part;
    logic [PCNT_BITS-1:0] r_pcnt;

    t_word                n_sum;
    t_part                n_part;
    logic [PCNT_BITS-1:0] n_pcnt;

    logic [BCNT_BITS-1:0] cnt_sat;
    t_word                data_m;
    t_word                low;
    t_word                high;
    logic [BCNT_BITS-1:0] total;
    logic [5:0]           sh_lo;

    always_comb begin
        cnt_sat = (i_cnt > BCNT_BITS'(WORD_BYTES)) ? BCNT_BITS'(WORD_BYTES) : i_cnt;
        for (int k = 0; k < WORD_BYTES; k++) begin
            data_m[8*k +: 8] = (BCNT_BITS'(k) < cnt_sat) ? i_data[8*k +: 8] : 8'h00;
        end
        sh_lo = {r_pcnt, 3'b000};
        low   = {8'h00, r_part} | (data_m << sh_lo);
        high  = (r_pcnt == '0) ? '0 : (data_m >> (6'd0 - sh_lo));
        total = BCNT_BITS'(r_pcnt) + cnt_sat;
        if (total >= BCNT_BITS'(WORD_BYTES)) begin
            n_sum  = mul17_add(r_sum, low);
            n_part = high[PART_BITS-1:0];
            n_pcnt = total[PCNT_BITS-1:0];
        end else begin
            n_sum  = r_sum;
            n_part = low[PART_BITS-1:0];
            n_pcnt = total[PCNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_part <= '0;
            r_pcnt <= '0;
        end else if (i_go) begin
            if (i_last) begin
                r_sum  <= '0;
                r_part <= '0;
                r_pcnt <= '0;
            end else begin
                r_sum  <= n_sum;
                r_part <= n_part;
                r_pcnt <= n_pcnt;
            end
        end
    end

    assign o_fin.sum  = n_sum;
    assign o_fin.part = n_part;
    assign o_fin.pend = (n_pcnt != '0);

endmodule

// ===== hdl/wm17_fold.sv =====
// Final partial-word fold, 32-bit inversion fold and result register.
module wm17_fold
    import wm17_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fin_valid,
    input  t_fin                 i_fin,
    output logic                 o_fin_ready,
    output logic                 o_out_valid,
    output logic [CSUM_BITS-1:0] o_checksum,
    input  logic                 i_out_ready
);

    logic                 r_b_valid;
    t_fin                 r_b_fin;
    logic                 r_c_valid;
    logic [CSUM_BITS-1:0] r_c_sum;

    logic                 c_free;
    logic                 b_free;
    t_word                s;
    logic [CSUM_BITS-1:0] n_c_sum;

    assign c_free      = !r_c_valid || i_out_ready;
    assign b_free      = !r_b_valid || c_free;
    assign o_fin_ready = b_free;

    always_comb begin
        s = r_b_fin.pend ? mul17_add(r_b_fin.sum, {8'h00, r_b_fin.part}) : r_b_fin.sum;
        n_c_sum = ~(s[CSUM_BITS-1:0] ^ s[WORD_BITS-1:CSUM_BITS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_valid <= i_fin_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && i_fin_valid) begin
            r_b_fin <= i_fin;
        end
        if (c_free && r_b_valid) begin
            r_c_sum <= n_c_sum;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_checksum  = r_c_sum;

endmodule
